### hdl/mwc_pkg.sv
package mwc_pkg;

  localparam int FIELD_W  = 18;
  localparam int SUM_W    = 21;
  localparam int OUT_W    = 16;
  localparam int COUNT_W  = 3;
  localparam int MAX_FRAC = 14;
  localparam int NUM_W    = SUM_W + MAX_FRAC;
  localparam int ITER_W   = $clog2(NUM_W);

  typedef enum logic [2:0] {
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic add;
    logic clear;
  } acc_ctl_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

endpackage

### hdl/mwc_if.sv
interface mwc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mwc_pkg::FIELD_W-1:0] alpha_value;
  logic signed [mwc_pkg::FIELD_W-1:0] beta_value;
  logic                                include_req;

  modport source (output valid, output alpha_value, output beta_value,
                  output include_req, input ready);
  modport sink (input valid, input alpha_value, input beta_value,
                input include_req, output ready);
endinterface

interface mwc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mwc_pkg::OUT_W-1:0] eta_result;
  logic                              div_by_zero;

  modport source (output valid, output eta_result, output div_by_zero, input ready);
  modport sink (input valid, input eta_result, input div_by_zero, output ready);
endinterface

### hdl/mwc_accum.sv
module mwc_accum #(
  parameter int EXT_W = 18
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mwc_pkg::acc_ctl_t                   ctl,
  input  logic signed [mwc_pkg::FIELD_W-1:0] alpha_value,
  input  logic signed [mwc_pkg::FIELD_W-1:0] beta_value,
  input  logic                                include_req,
  output logic signed [mwc_pkg::SUM_W-1:0]   alpha_total,
  output logic signed [mwc_pkg::SUM_W-1:0]   beta_total,
  output logic [mwc_pkg::COUNT_W-1:0]        tower_count
);

  logic signed [mwc_pkg::SUM_W-1:0] alpha_ext;
  logic signed [mwc_pkg::SUM_W-1:0] beta_ext;

  assign alpha_ext = {{(mwc_pkg::SUM_W - EXT_W){alpha_value[EXT_W-1]}},
                      alpha_value[EXT_W-1:0]};
  assign beta_ext  = {{(mwc_pkg::SUM_W - EXT_W){beta_value[EXT_W-1]}},
                      beta_value[EXT_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      alpha_total <= '0;
      beta_total  <= '0;
      tower_count <= '0;
    end else if (ctl.add) begin
      tower_count <= tower_count + 1'b1;
      if (include_req) begin
        alpha_total <= alpha_total + alpha_ext;
        beta_total  <= beta_total + beta_ext;
      end
    end
  end

endmodule

### hdl/mwc_div.sv
module mwc_div #(
  parameter int FRAC_BITS = 10
) (
  input  logic                               clk,
  input  mwc_pkg::div_ctl_t                  ctl,
  input  logic signed [mwc_pkg::SUM_W-1:0]  alpha_total,
  input  logic signed [mwc_pkg::SUM_W-1:0]  beta_total,
  output logic signed [mwc_pkg::OUT_W-1:0]  eta_result,
  output logic                               div_by_zero
);

  localparam int NW = mwc_pkg::NUM_W;
  localparam int SW = mwc_pkg::SUM_W;

  logic [NW-1:0] quo_num;
  logic [SW-1:0] rem;
  logic [SW-1:0] dvs;
  logic          neg;
  logic          zero;

  logic [SW-1:0] amag;
  logic [SW-1:0] bmag;
  logic [SW:0]   rem_sh;
  logic [SW:0]   diff;
  logic          fits;
  logic          pos_ovf;
  logic          neg_ovf;

  assign amag   = alpha_total[SW-1] ? SW'(-alpha_total) : SW'(alpha_total);
  assign bmag   = beta_total[SW-1] ? SW'(-beta_total) : SW'(beta_total);
  assign rem_sh = {rem, quo_num[NW-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign fits   = !diff[SW];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      quo_num <= NW'({{(NW - SW){1'b0}}, amag} << FRAC_BITS);
      rem     <= '0;
      dvs     <= bmag;
      neg     <= alpha_total[SW-1] ^ beta_total[SW-1];
      zero    <= (beta_total == '0);
    end else if (ctl.step) begin
      if (fits) begin
        rem <= diff[SW-1:0];
      end else begin
        rem <= rem_sh[SW-1:0];
      end
      quo_num <= {quo_num[NW-2:0], fits};
    end
  end

  assign pos_ovf = (quo_num[NW-1:mwc_pkg::OUT_W-1] != '0);
  assign neg_ovf = (quo_num[NW-1:mwc_pkg::OUT_W] != '0) ||
                   (quo_num[mwc_pkg::OUT_W-1] && (quo_num[mwc_pkg::OUT_W-2:0] != '0));

  always_comb begin
    div_by_zero = zero;
    priority if (zero) begin
      eta_result = '0;
    end else if (neg && neg_ovf) begin
      eta_result = {1'b1, {(mwc_pkg::OUT_W-1){1'b0}}};
    end else if (!neg && pos_ovf) begin
      eta_result = {1'b0, {(mwc_pkg::OUT_W-1){1'b1}}};
    end else if (neg) begin
      eta_result = -quo_num[mwc_pkg::OUT_W-1:0];
    end else begin
      eta_result = quo_num[mwc_pkg::OUT_W-1:0];
    end
  end

endmodule

### hdl/masked_weighted_centroid.sv
// Energy-weighted centroid over a fixed group of NUM_TOWERS towers.
// The in_ch channel takes one tower per transfer: alpha, beta and an include
// bit. Included towers are added into 21-bit running sums. The
// last tower of a group starts a restoring division of the alpha sum, scaled
// by 2^OUT_FRAC_BITS, by the beta sum, one quotient bit per cycle on a single
// shared subtractor. A tower that does not close a group leaves in_ch ready
// for the next tower. The closing tower passes through a load step, 35
// divide steps and a finish step that saturates and rounds toward zero.
// Its result appears on out_ch in the cycle after the finish step.
// The result sits in an output register, so the next group's towers are
// taken while it waits; if the receiver stalls, the block holds its finished
// quotient and takes no further tower until the output register frees.
// A zero beta sum gives eta_result 0 with div_by_zero set.
// Reset clears the sums, the tower count, the sequencer and the output valid.
module masked_weighted_centroid #(
  parameter int NUM_TOWERS    = 7,
  parameter int IN_WIDTH      = 18,
  parameter int OUT_FRAC_BITS = 10
) (
  input  logic             clk,
  input  logic             rst,
  mwc_in_if.sink           in_ch,
  mwc_out_if.source        out_ch
);

  localparam int EXT_W = (IN_WIDTH < mwc_pkg::FIELD_W) ? IN_WIDTH : mwc_pkg::FIELD_W;

  mwc_pkg::state_t   state;
  mwc_pkg::state_t   state_next;
  mwc_pkg::acc_ctl_t acc_ctl;
  mwc_pkg::div_ctl_t div_ctl;

  logic [mwc_pkg::ITER_W-1:0]        iter;
  logic signed [mwc_pkg::SUM_W-1:0] alpha_total;
  logic signed [mwc_pkg::SUM_W-1:0] beta_total;
  logic [mwc_pkg::COUNT_W-1:0]      tower_count;
  logic signed [mwc_pkg::OUT_W-1:0] div_eta;
  logic                              div_zero;
  logic                              in_fire;
  logic                              last_tower;
  logic                              slot_free;
  logic                              out_load;
  logic                              out_valid;
  logic signed [mwc_pkg::OUT_W-1:0] out_eta;
  logic                              out_dbz;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign last_tower = (tower_count == mwc_pkg::COUNT_W'(NUM_TOWERS - 1));
  assign slot_free  = !out_valid || out_ch.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      mwc_pkg::ST_ACC: begin
        if (in_fire && last_tower) begin
          state_next = mwc_pkg::ST_LOAD;
        end
      end
      mwc_pkg::ST_LOAD: begin
        state_next = mwc_pkg::ST_DIV;
      end
      mwc_pkg::ST_DIV: begin
        if (iter == mwc_pkg::ITER_W'(mwc_pkg::NUM_W - 1)) begin
          state_next = mwc_pkg::ST_FIN;
        end
      end
      mwc_pkg::ST_FIN: begin
        if (slot_free) begin
          state_next = mwc_pkg::ST_ACC;
        end
      end
      default: state_next = mwc_pkg::ST_ACC;
    endcase
  end

  always_comb begin
    in_ch.ready   = 1'b0;
    acc_ctl.add   = 1'b0;
    acc_ctl.clear = 1'b0;
    div_ctl.load  = 1'b0;
    div_ctl.step  = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      mwc_pkg::ST_ACC: begin
        in_ch.ready = 1'b1;
        acc_ctl.add = in_ch.valid;
      end
      mwc_pkg::ST_LOAD: begin
        div_ctl.load  = 1'b1;
        acc_ctl.clear = 1'b1;
      end
      mwc_pkg::ST_DIV: begin
        div_ctl.step = 1'b1;
      end
      mwc_pkg::ST_FIN: begin
        out_load = slot_free;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mwc_pkg::ST_ACC;
      iter  <= '0;
    end else begin
      state <= state_next;
      if (div_ctl.step) begin
        iter <= iter + 1'b1;
      end else begin
        iter <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_eta <= div_eta;
      out_dbz <= div_zero;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.eta_result  = out_eta;
  assign out_ch.div_by_zero = out_dbz;

  mwc_accum #(
    .EXT_W(EXT_W)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .ctl         (acc_ctl),
    .alpha_value (in_ch.alpha_value),
    .beta_value  (in_ch.beta_value),
    .include_req (in_ch.include_req),
    .alpha_total (alpha_total),
    .beta_total  (beta_total),
    .tower_count (tower_count)
  );

  mwc_div #(
    .FRAC_BITS(OUT_FRAC_BITS)
  ) u_div (
    .clk         (clk),
    .ctl         (div_ctl),
    .alpha_total (alpha_total),
    .beta_total  (beta_total),
    .eta_result  (div_eta),
    .div_by_zero (div_zero)
  );

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.div_by_zero |-> out_ch.eta_result == '0)
    else $error("Zero beta sum delivered a nonzero result.");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    tower_count <= mwc_pkg::COUNT_W'(NUM_TOWERS))
    else $error("Tower count passed the group size.");

  a_group_clear: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_tower |=> ##1 (tower_count == '0 && alpha_total == '0))
    else $error("Sums did not clear after the closing tower.");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == mwc_pkg::ST_FIN)
    else $error("Result appeared outside the finish step.");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    state == mwc_pkg::ST_LOAD |=> ##(mwc_pkg::NUM_W) state == mwc_pkg::ST_FIN)
    else $error("Division did not take the fixed number of steps.");

endmodule
